/* hdl/smooth_weighted_round_robin_picker_core_macros.svh */
// Assertion helpers used by the checker file.
`ifndef SMOOTH_WEIGHTED_ROUND_ROBIN_PICKER_CORE_MACROS_SVH
`define SMOOTH_WEIGHTED_ROUND_ROBIN_PICKER_CORE_MACROS_SVH

// Clocked assertion, masked while reset is applied.
`define SWRR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define SWRR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/swrr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package swrr_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_BACKENDS_DEF = 8;
  localparam int unsigned WEIGHT_BITS_DEF  = 8;

  // Fixed field widths
  localparam int unsigned IDX_W          = 3;
  localparam int unsigned MODE_W         = 2;
  localparam int unsigned COUNT_W        = 4;
  localparam int unsigned WEIGHT_TABLE_W = 64;
  localparam int unsigned DOWN_W         = 8;
  localparam int unsigned CREDIT_W       = 13;

  // APB register port
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 64;

  // Health counter limits
  localparam logic [1:0] OK_SATURATE  = 2'd3;
  localparam logic [1:0] OK_THRESHOLD = 2'd2;

  // Register reset values
  localparam logic [COUNT_W-1:0]        BACKEND_COUNT_RST = 4'd1;
  localparam logic [WEIGHT_TABLE_W-1:0] WEIGHT_TABLE_RST  = 64'h0101_0101_0101_0101;
  localparam logic [DOWN_W-1:0]         DOWN_MASK_RST     = 8'h00;

  typedef enum logic [1:0] {
    REG_BACKEND_COUNT = 2'd0,
    REG_WEIGHT_TABLE  = 2'd1,
    REG_DOWN_MASK     = 2'd2
  } reg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_PICK    = 2'd0,
    MODE_OK      = 2'd1,
    MODE_FAIL    = 2'd2,
    MODE_INVALID = 2'd3
  } mode_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUB,
    ST_HEALTH,
    ST_DONE
  } state_e;

  // Configuration handed from the register file to the engine
  typedef struct packed {
    logic [COUNT_W-1:0]        backend_count;
    logic [WEIGHT_TABLE_W-1:0] weight_table;
    logic [DOWN_W-1:0]         down_mask;
  } cfg_t;

endpackage

`default_nettype wire

/* hdl/smooth_weighted_round_robin_picker_core.sv */
// Channel   | Signals                                        | Handshake
// ----------+------------------------------------------------+-------------------------
// command   | mode_i, backend_index_i                        | start && !busy
// result    | found_o, chosen_backend_o, offline_now_o       | done_o, one cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata   | APB, pready tied high
//
// Pick: states SCAN, SUB and DONE follow the accept; SUB is skipped when no backend
// is eligible (no write-back). The scan covers the backend count clamped to
// MAX_BACKENDS and feeds one backend per cycle through the shared saturating adder,
// which then writes back the winner's credit.
// Health event: HEALTH then DONE states; undefined mode: DONE state only.
// busy stays high from accept through the done_o cycle.
// Reset: credits zero, all online, health counts zero, registers at defaults.
// The receiver cannot stall; done_o marks each result word for one cycle only.
`timescale 1ns / 1ps
`default_nettype none

module smooth_weighted_round_robin_picker_core #(
  parameter int unsigned MAX_BACKENDS = swrr_pkg::MAX_BACKENDS_DEF,
  parameter int unsigned WEIGHT_BITS  = swrr_pkg::WEIGHT_BITS_DEF
) (
  input  var logic                            clk_i,
  input  var logic                            rst_ni,
  // command
  input  var logic                            start,
  output logic                                busy,
  input  var logic [swrr_pkg::MODE_W-1:0]     mode_i,
  input  var logic [swrr_pkg::IDX_W-1:0]      backend_index_i,
  // result
  output logic                                done_o,
  output logic                                found_o,
  output logic [swrr_pkg::IDX_W-1:0]          chosen_backend_o,
  output logic                                offline_now_o,
  // configuration
  input  var logic                            psel,
  input  var logic                            penable,
  input  var logic                            pwrite,
  input  var logic [swrr_pkg::APB_ADDR_W-1:0] paddr,
  input  var logic [swrr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [swrr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  swrr_pkg::cfg_t cfg;
  logic           accept;

  assign accept = start && !busy;

  // register file
  swrr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencer and backend state
  swrr_engine #(
    .MAX_BACKENDS (MAX_BACKENDS),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (accept),
    .mode_i           (mode_i),
    .backend_index_i  (backend_index_i),
    .cfg_i            (cfg),
    .busy_o           (busy),
    .done_o           (done_o),
    .found_o          (found_o),
    .chosen_backend_o (chosen_backend_o),
    .offline_now_o    (offline_now_o)
  );

endmodule

`default_nettype wire

/* hdl/swrr_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

// Shared saturating credit adder: y = sat(a +/- b) over the credit range.
module swrr_alu #(
  parameter int unsigned TOTAL_W = 12
) (
  input  var swrr_pkg::alu_op_e                    op_i,
  input  var logic signed [swrr_pkg::CREDIT_W-1:0] a_i,
  input  var logic [TOTAL_W-1:0]                   b_i,
  output logic signed [swrr_pkg::CREDIT_W-1:0]     y_o
);

  localparam int unsigned CW    = swrr_pkg::CREDIT_W;
  localparam int unsigned SUM_W = ((CW > TOTAL_W) ? CW : TOTAL_W + 1) + 1;

  logic signed [SUM_W-1:0] a_ext;
  logic signed [SUM_W-1:0] b_ext;
  logic signed [SUM_W-1:0] sum;
  logic                    in_range;

  assign a_ext = {{(SUM_W-CW){a_i[CW-1]}}, a_i};
  assign b_ext = {{(SUM_W-TOTAL_W){1'b0}}, b_i};
  assign sum   = (op_i == swrr_pkg::ALU_SUB) ? (a_ext - b_ext) : (a_ext + b_ext);

  // in range when all bits above the credit sign agree with it
  assign in_range = (sum[SUM_W-1:CW-1] == {(SUM_W-CW+1){1'b0}}) ||
                    (sum[SUM_W-1:CW-1] == {(SUM_W-CW+1){1'b1}});

  always_comb begin
    if (in_range) begin
      y_o = sum[CW-1:0];
    end else if (sum[SUM_W-1]) begin
      y_o = {1'b1, {(CW-1){1'b0}}};
    end else begin
      y_o = {1'b0, {(CW-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

/* hdl/swrr_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

// APB register file: backend count, weight table, down mask.
module swrr_regs (
  input  var logic                              clk_i,
  input  var logic                              rst_ni,
  input  var logic                              psel,
  input  var logic                              penable,
  input  var logic                              pwrite,
  input  var logic [swrr_pkg::APB_ADDR_W-1:0]   paddr,
  input  var logic [swrr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [swrr_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready,
  output swrr_pkg::cfg_t                        cfg_o
);

  swrr_pkg::cfg_t     cfg_q;
  swrr_pkg::cfg_t     cfg_d;
  swrr_pkg::reg_idx_e reg_idx;
  logic               wr_en;

  // registers sit on 8-byte boundaries
  assign reg_idx = swrr_pkg::reg_idx_e'(paddr[4:3]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  // write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        swrr_pkg::REG_BACKEND_COUNT: begin
          cfg_d.backend_count = pwdata[swrr_pkg::COUNT_W-1:0];
        end
        swrr_pkg::REG_WEIGHT_TABLE: begin
          cfg_d.weight_table = pwdata[swrr_pkg::WEIGHT_TABLE_W-1:0];
        end
        swrr_pkg::REG_DOWN_MASK: begin
          cfg_d.down_mask = pwdata[swrr_pkg::DOWN_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      swrr_pkg::REG_BACKEND_COUNT: begin
        prdata = {{(swrr_pkg::APB_DATA_W-swrr_pkg::COUNT_W){1'b0}}, cfg_q.backend_count};
      end
      swrr_pkg::REG_WEIGHT_TABLE: begin
        prdata = cfg_q.weight_table;
      end
      swrr_pkg::REG_DOWN_MASK: begin
        prdata = {{(swrr_pkg::APB_DATA_W-swrr_pkg::DOWN_W){1'b0}}, cfg_q.down_mask};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.backend_count <= swrr_pkg::BACKEND_COUNT_RST;
      cfg_q.weight_table  <= swrr_pkg::WEIGHT_TABLE_RST;
      cfg_q.down_mask     <= swrr_pkg::DOWN_MASK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hdl/swrr_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sequencer and per-backend state. A pick walks one backend per cycle
// through the shared saturating adder, then reuses it for the write-back.
module swrr_engine #(
  parameter int unsigned MAX_BACKENDS = swrr_pkg::MAX_BACKENDS_DEF,
  parameter int unsigned WEIGHT_BITS  = swrr_pkg::WEIGHT_BITS_DEF
) (
  input  var logic                          clk_i,
  input  var logic                          rst_ni,
  input  var logic                          start_i,
  input  var logic [swrr_pkg::MODE_W-1:0]   mode_i,
  input  var logic [swrr_pkg::IDX_W-1:0]    backend_index_i,
  input  var swrr_pkg::cfg_t                cfg_i,
  output logic                              busy_o,
  output logic                              done_o,
  output logic                              found_o,
  output logic [swrr_pkg::IDX_W-1:0]        chosen_backend_o,
  output logic                              offline_now_o
);

  localparam int unsigned CW      = swrr_pkg::CREDIT_W;
  localparam int unsigned IW      = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_BACKENDS + 1);
  localparam int unsigned TOTAL_W = WEIGHT_BITS + CNT_W;

  // control
  swrr_pkg::state_e state_q, state_d;
  logic             have_best_q, have_best_d;
  logic             found_q, found_d;
  logic [swrr_pkg::IDX_W-1:0] chosen_q, chosen_d;
  logic             offline_q, offline_d;

  // working registers
  logic [CNT_W-1:0]        i_q, i_d;
  logic [CNT_W-1:0]        n_q, n_d;
  logic [IW-1:0]           best_q, best_d;
  logic signed [CW-1:0]    best_credit_q, best_credit_d;
  logic [TOTAL_W-1:0]      total_q, total_d;
  swrr_pkg::mode_e         mode_q, mode_d;
  logic [swrr_pkg::IDX_W-1:0] hidx_q, hidx_d;

  // per-backend state
  logic [CW-1:0] credit_q [MAX_BACKENDS];
  logic [CW-1:0] credit_d [MAX_BACKENDS];
  logic          offline_flag_q [MAX_BACKENDS];
  logic          offline_flag_d [MAX_BACKENDS];
  logic [1:0]    ok_cnt_q [MAX_BACKENDS];
  logic [1:0]    ok_cnt_d [MAX_BACKENDS];

  // helpers
  logic [CNT_W-1:0]       cnt_clamp;
  logic [IW-1:0]          scan_idx;
  logic [IW-1:0]          rd_idx;
  logic [WEIGHT_BITS-1:0] w;
  logic [TOTAL_W-1:0]     w_ext;
  logic                   eligible;
  logic                   scan_more;
  swrr_pkg::alu_op_e      alu_op;
  logic signed [CW-1:0]   alu_a;
  logic [TOTAL_W-1:0]     alu_b;
  logic signed [CW-1:0]   alu_y;
  logic                   h_in_range;
  logic [IW-1:0]          hsel;
  logic [1:0]             ok_next;

  // effective backend count, clamped to the table size
  assign cnt_clamp = (cfg_i.backend_count > swrr_pkg::COUNT_W'(MAX_BACKENDS)) ?
                     CNT_W'(MAX_BACKENDS) : cfg_i.backend_count[CNT_W-1:0];

  assign scan_idx  = i_q[IW-1:0];
  assign scan_more = (i_q < n_q);
  assign w         = cfg_i.weight_table[{scan_idx, 3'b000} +: WEIGHT_BITS];
  assign w_ext     = {{(TOTAL_W-WEIGHT_BITS){1'b0}}, w};
  assign eligible  = !cfg_i.down_mask[scan_idx] && (w != '0) && !offline_flag_q[scan_idx];

  // shared adder: credit + weight while scanning, credit - total at write-back
  assign rd_idx = (state_q == swrr_pkg::ST_SUB) ? best_q : scan_idx;
  assign alu_op = (state_q == swrr_pkg::ST_SUB) ? swrr_pkg::ALU_SUB : swrr_pkg::ALU_ADD;
  assign alu_a  = credit_q[rd_idx];
  assign alu_b  = (state_q == swrr_pkg::ST_SUB) ? total_q : w_ext;

  swrr_alu #(
    .TOTAL_W (TOTAL_W)
  ) u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y)
  );

  // health event addressing
  assign h_in_range = ({1'b0, hidx_q} < swrr_pkg::COUNT_W'(MAX_BACKENDS));
  assign hsel       = hidx_q[IW-1:0];
  assign ok_next    = (ok_cnt_q[hsel] == swrr_pkg::OK_SATURATE) ?
                      swrr_pkg::OK_SATURATE : (ok_cnt_q[hsel] + 2'd1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      swrr_pkg::ST_IDLE: begin
        if (start_i) begin
          case (swrr_pkg::mode_e'(mode_i))
            swrr_pkg::MODE_PICK: state_d = swrr_pkg::ST_SCAN;
            swrr_pkg::MODE_OK,
            swrr_pkg::MODE_FAIL: state_d = swrr_pkg::ST_HEALTH;
            default:             state_d = swrr_pkg::ST_DONE;
          endcase
        end
      end
      swrr_pkg::ST_SCAN: begin
        if (!scan_more) begin
          state_d = have_best_q ? swrr_pkg::ST_SUB : swrr_pkg::ST_DONE;
        end
      end
      swrr_pkg::ST_SUB:    state_d = swrr_pkg::ST_DONE;
      swrr_pkg::ST_HEALTH: state_d = swrr_pkg::ST_DONE;
      swrr_pkg::ST_DONE:   state_d = swrr_pkg::ST_IDLE;
      default:             state_d = swrr_pkg::ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    have_best_d    = have_best_q;
    found_d        = found_q;
    chosen_d       = chosen_q;
    offline_d      = offline_q;
    i_d            = i_q;
    n_d            = n_q;
    best_d         = best_q;
    best_credit_d  = best_credit_q;
    total_d        = total_q;
    mode_d         = mode_q;
    hidx_d         = hidx_q;
    credit_d       = credit_q;
    offline_flag_d = offline_flag_q;
    ok_cnt_d       = ok_cnt_q;

    case (state_q)
      swrr_pkg::ST_IDLE: begin
        if (start_i) begin
          mode_d      = swrr_pkg::mode_e'(mode_i);
          hidx_d      = backend_index_i;
          i_d         = '0;
          n_d         = cnt_clamp;
          have_best_d = 1'b0;
          total_d     = '0;
          found_d     = 1'b0;
          chosen_d    = '0;
          offline_d   = 1'b0;
        end
      end
      swrr_pkg::ST_SCAN: begin
        if (scan_more) begin
          i_d = i_q + CNT_W'(1);
          if (eligible) begin
            credit_d[scan_idx] = alu_y;
            total_d            = total_q + w_ext;
            // strict compare keeps the lowest index on ties
            if (!have_best_q || (alu_y > best_credit_q)) begin
              have_best_d   = 1'b1;
              best_d        = scan_idx;
              best_credit_d = alu_y;
            end
          end
        end
      end
      swrr_pkg::ST_SUB: begin
        credit_d[best_q] = alu_y;
        found_d          = 1'b1;
        chosen_d         = swrr_pkg::IDX_W'(best_q);
        offline_d        = 1'b0;
      end
      swrr_pkg::ST_HEALTH: begin
        found_d  = 1'b1;
        chosen_d = hidx_q;
        if (h_in_range) begin
          if (mode_q == swrr_pkg::MODE_FAIL) begin
            ok_cnt_d[hsel]       = 2'd0;
            offline_flag_d[hsel] = 1'b1;
            offline_d            = 1'b1;
          end else begin
            ok_cnt_d[hsel] = ok_next;
            if (ok_next > swrr_pkg::OK_THRESHOLD) begin
              offline_flag_d[hsel] = 1'b0;
              offline_d            = 1'b0;
            end else begin
              offline_d = offline_flag_q[hsel];
            end
          end
        end
      end
      default: begin
        found_d = found_q;
      end
    endcase
  end

  // control and per-backend state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swrr_pkg::ST_IDLE;
      have_best_q <= 1'b0;
      found_q     <= 1'b0;
      chosen_q    <= '0;
      offline_q   <= 1'b0;
      for (int k = 0; k < MAX_BACKENDS; k++) begin
        credit_q[k]       <= '0;
        offline_flag_q[k] <= 1'b0;
        ok_cnt_q[k]       <= 2'd0;
      end
    end else begin
      state_q        <= state_d;
      have_best_q    <= have_best_d;
      found_q        <= found_d;
      chosen_q       <= chosen_d;
      offline_q      <= offline_d;
      credit_q       <= credit_d;
      offline_flag_q <= offline_flag_d;
      ok_cnt_q       <= ok_cnt_d;
    end
  end

  // working registers, loaded at accept
  always_ff @(posedge clk_i) begin
    i_q           <= i_d;
    n_q           <= n_d;
    best_q        <= best_d;
    best_credit_q <= best_credit_d;
    total_q       <= total_d;
    mode_q        <= mode_d;
    hidx_q        <= hidx_d;
  end

  assign busy_o           = (state_q != swrr_pkg::ST_IDLE);
  assign done_o           = (state_q == swrr_pkg::ST_DONE);
  assign found_o          = found_q;
  assign chosen_backend_o = chosen_q;
  assign offline_now_o    = offline_q;

endmodule

`default_nettype wire

/* hdl/swrr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "smooth_weighted_round_robin_picker_core_macros.svh"

// Port-level checks on the command and result channels.
module swrr_checker (
  input var logic                         clk_i,
  input var logic                         rst_ni,
  input var logic                         start,
  input var logic                         busy,
  input var logic                         done_o,
  input var logic                         found_o,
  input var logic [swrr_pkg::IDX_W-1:0]   chosen_backend_o,
  input var logic                         offline_now_o
);

  // an accepted command word keeps the block busy
  `SWRR_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy, "accept did not raise busy")

  // result strobe lasts one cycle and lies inside the busy window
  `SWRR_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o, "done_o held for two cycles")
  `SWRR_ASSERT(a_done_busy, clk_i, rst_ni, done_o |-> busy, "done_o while not busy")

  // a miss reports index zero and online
  `SWRR_ASSERT(a_miss_clean, clk_i, rst_ni, (done_o && !found_o) |-> ((chosen_backend_o == '0) && !offline_now_o), "miss result not cleared")

  // no result word comes out of reset
  `SWRR_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !done_o, "done_o during reset")

endmodule

bind smooth_weighted_round_robin_picker_core swrr_checker u_swrr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .found_o          (found_o),
  .chosen_backend_o (chosen_backend_o),
  .offline_now_o    (offline_now_o)
);

`default_nettype wire

/* bench/tb_smooth_weighted_round_robin_picker_core.sv */
`timescale 1ns / 1ps

module tb_smooth_weighted_round_robin_picker_core;
  import swrr_pkg::*;

  localparam int NUM_BE = MAX_BACKENDS_DEF;
  localparam int RANDOM_ITEMS = 800;
  localparam int DIR_ROWS = 35;
  // Address slot past the last register; writes there must be dropped
  localparam logic [1:0] REG_SPARE = 2'd3;

  // One result word as seen on the output ports
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] chosen;
    logic             offline;
  } outcome_t;

  // Directed stimulus row: either a register write or a command word
  typedef struct packed {
    logic             is_cfg;
    logic [1:0]       sel;
    logic [63:0]      value;
    mode_e            mode;
    logic [IDX_W-1:0] idx;
    logic             checked;
    outcome_t         want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // out of reset: one backend, weight one
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_PICK,    3'd0, 1'b1, '{1'b1, 3'd0, 1'b0}},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_INVALID, 3'd5, 1'b1, '{1'b0, 3'd0, 1'b0}},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_OK,      3'd7, 1'b1, '{1'b1, 3'd7, 1'b0}},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_FAIL,    3'd0, 1'b1, '{1'b1, 3'd0, 1'b1}},
    // only backend offline: nothing eligible
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_PICK,    3'd3, 1'b1, '{1'b0, 3'd0, 1'b0}},
    // three successes bring it back, fourth saturates
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_OK,      3'd0, 1'b1, '{1'b1, 3'd0, 1'b1}},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_OK,      3'd0, 1'b1, '{1'b1, 3'd0, 1'b1}},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_OK,      3'd0, 1'b1, '{1'b1, 3'd0, 1'b0}},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_OK,      3'd0, 1'b1, '{1'b1, 3'd0, 1'b0}},
    // health event beyond the backend count still lands
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_FAIL,    3'd5, 1'b1, '{1'b1, 3'd5, 1'b1}},
    // count above the limit, all weights at max
    '{1'b1, REG_BACKEND_COUNT, 64'hFFFF_FFFF_FFFF_FFFF, MODE_PICK, 3'd0, 1'b0, '0},
    '{1'b1, REG_WEIGHT_TABLE,  64'hFFFF_FFFF_FFFF_FFFF, MODE_PICK, 3'd0, 1'b0, '0},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_PICK,    3'd0, 1'b0, '0},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_PICK,    3'd6, 1'b0, '0},
    // all weights zero
    '{1'b1, REG_WEIGHT_TABLE,  64'h0, MODE_PICK,    3'd0, 1'b0, '0},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_PICK,    3'd0, 1'b1, '{1'b0, 3'd0, 1'b0}},
    // mixed weights, then everything administratively down
    '{1'b1, REG_WEIGHT_TABLE,  64'h8001_FF00_7F40_0201, MODE_PICK, 3'd0, 1'b0, '0},
    '{1'b1, REG_DOWN_MASK,     64'hFFFF_FFFF_FFFF_FFFF, MODE_PICK, 3'd0, 1'b0, '0},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_PICK,    3'd0, 1'b1, '{1'b0, 3'd0, 1'b0}},
    '{1'b1, REG_DOWN_MASK,     64'hFFFF_FF00_0000_0055, MODE_PICK, 3'd0, 1'b0, '0},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_PICK,    3'd0, 1'b0, '0},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_PICK,    3'd0, 1'b0, '0},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_PICK,    3'd0, 1'b0, '0},
    // count of zero, upper bits of the write dropped
    '{1'b1, REG_BACKEND_COUNT, 64'h0000_0000_0000_00F0, MODE_PICK, 3'd0, 1'b0, '0},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_PICK,    3'd0, 1'b1, '{1'b0, 3'd0, 1'b0}},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_OK,      3'd3, 1'b0, '0},
    // unmapped slot, then full count with nothing down
    '{1'b1, REG_SPARE,         64'h3, MODE_PICK,    3'd0, 1'b0, '0},
    '{1'b1, REG_BACKEND_COUNT, 64'h8, MODE_PICK,    3'd0, 1'b0, '0},
    '{1'b1, REG_DOWN_MASK,     64'h0, MODE_PICK,    3'd0, 1'b0, '0},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_PICK,    3'd0, 1'b0, '0},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_OK,      3'd5, 1'b0, '0},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_OK,      3'd5, 1'b0, '0},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_OK,      3'd5, 1'b0, '0},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_PICK,    3'd0, 1'b0, '0},
    '{1'b0, REG_BACKEND_COUNT, 64'h0, MODE_FAIL,    3'd7, 1'b1, '{1'b1, 3'd7, 1'b1}}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [MODE_W-1:0]     mode_i;
  logic [IDX_W-1:0]      backend_index_i;
  logic                  done_o;
  logic                  found_o;
  logic [IDX_W-1:0]      chosen_backend_o;
  logic                  offline_now_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Shadow copy of the registers and the per-backend state
  logic [COUNT_W-1:0]        sh_count;
  logic [WEIGHT_TABLE_W-1:0] sh_weights;
  logic [DOWN_W-1:0]         sh_down;
  logic signed [CREDIT_W-1:0] credit_m [NUM_BE];
  logic                       offline_m [NUM_BE];
  logic [1:0]                 ok_cnt_m [NUM_BE];

  outcome_t awaited [$];
  int       mismatches = 0;
  bit       idle_on = 1'b1;

  smooth_weighted_round_robin_picker_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .mode_i           (mode_i),
    .backend_index_i  (backend_index_i),
    .done_o           (done_o),
    .found_o          (found_o),
    .chosen_backend_o (chosen_backend_o),
    .offline_now_o    (offline_now_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Overall run limit
  initial begin
    #5000000;
    $display("FAIL smooth_weighted_round_robin_picker_core");
    $finish;
  end

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Credit clamp to the 13-bit signed range
  function automatic int clamp_credit(int v);
    if (v > 4095) return 4095;
    if (v < -4096) return -4096;
    return v;
  endfunction

  // Advance the shadow state by one command word and return its result word
  function automatic outcome_t apply_event(mode_e m, logic [IDX_W-1:0] b);
    int       n;
    int       total;
    int       best;
    int       w;
    int       c;
    outcome_t res;
    res = '0;
    if (m == MODE_PICK) begin
      n = (sh_count > NUM_BE) ? NUM_BE : int'(sh_count);
      total = 0;
      best = -1;
      for (int i = 0; i < n; i++) begin
        w = int'(sh_weights[8*i +: 8]);
        if (sh_down[i] || w < 1 || offline_m[i]) continue;
        total += w;
        c = int'(credit_m[i]);
        credit_m[i] = CREDIT_W'(clamp_credit(c + w));
        if (best < 0 || credit_m[i] > credit_m[best]) best = i;
      end
      if (best >= 0) begin
        c = int'(credit_m[best]);
        credit_m[best] = CREDIT_W'(clamp_credit(c - total));
        res.found = 1'b1;
        res.chosen = best[IDX_W-1:0];
      end
    end else if (m == MODE_OK || m == MODE_FAIL) begin
      res.found = 1'b1;
      res.chosen = b;
      if (m == MODE_FAIL) begin
        ok_cnt_m[b] = 2'd0;
        offline_m[b] = 1'b1;
      end else begin
        if (ok_cnt_m[b] < OK_SATURATE) ok_cnt_m[b] = ok_cnt_m[b] + 2'd1;
        if (ok_cnt_m[b] > OK_THRESHOLD) offline_m[b] = 1'b0;
      end
      res.offline = offline_m[b];
    end
    return res;
  endfunction

  // Present one command word; predicted (or given) result queued at accept
  task automatic send_word(mode_e m, logic [IDX_W-1:0] b, logic checked, outcome_t want);
    outcome_t pred;
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    mode_i <= m;
    backend_index_i <= b;
    do @(posedge clk_i); while (busy);
    pred = apply_event(m, b);
    if (checked) pred = want;
    awaited = {awaited, pred};
  endtask

  // Drop start and wait for every outstanding result word
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (awaited.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // APB write, then read back and compare for mapped registers
  task automatic write_reg(logic [1:0] sel, logic [63:0] data);
    logic [63:0] want;
    logic [63:0] mask;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 3'b000};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    mask = '0;
    want = '0;
    case (sel)
      REG_BACKEND_COUNT: begin
        sh_count = data[COUNT_W-1:0];
        mask = 64'hF;
        want = 64'(sh_count);
      end
      REG_WEIGHT_TABLE: begin
        sh_weights = data;
        mask = '1;
        want = sh_weights;
      end
      REG_DOWN_MASK: begin
        sh_down = data[DOWN_W-1:0];
        mask = 64'hFF;
        want = 64'(sh_down);
      end
      default: ;
    endcase
    if (sel != REG_SPARE) begin
      // back-to-back read of the same address
      @(negedge clk_i);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if ((prdata & mask) != want) flag_mismatch("register readback", prdata & mask, want);
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Result checker: each strobed word against the oldest expectation
  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni && done_o) begin
      if (awaited.size() == 0) begin
        flag_mismatch("unexpected result word",
                      64'({found_o, chosen_backend_o, offline_now_o}), 64'd0);
      end else begin
        want = awaited.pop_front();
        if (found_o !== want.found) flag_mismatch("found", 64'(found_o), 64'(want.found));
        if (chosen_backend_o !== want.chosen)
          flag_mismatch("chosen_backend", 64'(chosen_backend_o), 64'(want.chosen));
        if (offline_now_o !== want.offline)
          flag_mismatch("offline_now", 64'(offline_now_o), 64'(want.offline));
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [63:0]      v;
    logic [IDX_W-1:0] b;
    int               r;
    int               kind;
    int               phase_len;
    int               sent;
    bit               any;
    rst_ni = 1'b0;
    start = 1'b0;
    mode_i = MODE_PICK;
    backend_index_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sh_count = BACKEND_COUNT_RST;
    sh_weights = WEIGHT_TABLE_RST;
    sh_down = DOWN_MASK_RST;
    for (int i = 0; i < NUM_BE; i++) begin
      credit_m[i] = '0;
      offline_m[i] = 1'b0;
      ok_cnt_m[i] = 2'd0;
    end
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    for (int row = 0; row < DIR_ROWS; row++) begin
      if (DIRECTED[row].is_cfg) begin
        settle();
        write_reg(DIRECTED[row].sel, DIRECTED[row].value);
      end else begin
        send_word(DIRECTED[row].mode, DIRECTED[row].idx, DIRECTED[row].checked,
                  DIRECTED[row].want);
      end
    end

    // Random phases, each followed by a register reshuffle
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(60, 4);
      repeat (phase_len) begin
        idle_on = !(sent >= 300 && sent < 450);
        kind = $urandom_range(99);
        b = IDX_W'($urandom_range(NUM_BE - 1));
        if (kind < 8) begin
          // recovery burst: enough successes to come back online
          repeat (3) send_word(MODE_OK, b, 1'b0, '0);
          sent += 3;
        end else begin
          if (kind < 58) send_word(MODE_PICK, b, 1'b0, '0);
          else if (kind < 80) send_word(MODE_OK, b, 1'b0, '0);
          else if (kind < 93) send_word(MODE_FAIL, b, 1'b0, '0);
          else send_word(MODE_INVALID, b, 1'b0, '0);
          sent++;
        end
      end
      settle();
      any = 1'b0;
      if ($urandom_range(1)) begin
        v = {$urandom, $urandom};
        if ($urandom_range(1)) v[63:4] = '0;
        r = $urandom_range(99);
        if (r < 8) v[3:0] = 4'd0;
        else if (r < 16) v[3:0] = 4'($urandom_range(15, 9));
        else v[3:0] = 4'($urandom_range(8, 1));
        write_reg(REG_BACKEND_COUNT, v);
        any = 1'b1;
      end
      if ($urandom_range(1)) begin
        for (int k = 0; k < NUM_BE; k++) begin
          r = $urandom_range(99);
          if (r < 15) v[8*k +: 8] = 8'h00;
          else if (r < 25) v[8*k +: 8] = 8'hFF;
          else if (r < 60) v[8*k +: 8] = 8'($urandom_range(4, 1));
          else v[8*k +: 8] = 8'($urandom_range(255));
        end
        write_reg(REG_WEIGHT_TABLE, v);
        any = 1'b1;
      end
      if (!any || $urandom_range(1)) begin
        v = {$urandom, $urandom};
        if ($urandom_range(99) < 40) v[7:0] = 8'h00;
        else v[7:0] = v[7:0] & v[15:8];
        write_reg(REG_DOWN_MASK, v);
      end
      if ($urandom_range(19) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
    end

    // Drain and finish
    settle();
    repeat (12) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS smooth_weighted_round_robin_picker_core");
    end else begin
      $display("FAIL smooth_weighted_round_robin_picker_core");
    end
    $finish;
  end

endmodule
